@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// command and status codes, default sizes and the per-cell control group
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_PRIORITY_BITS = 32;
	localparam int DEF_TAG_BITS      = 16;

	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// holds one entry, compares it with the entry being inserted and takes its
// neighbor's entry on a shift
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS
) (
	input  logic                            clk,
	input  spq_pkg::cell_ctrl_t             ctrl,
	input  logic                            occupied,
	input  logic signed [PRIORITY_BITS-1:0] new_prio,
	input  logic        [TAG_BITS-1:0]      new_tag,
	input  logic                            below_ge,
	input  logic signed [PRIORITY_BITS-1:0] below_prio,
	input  logic        [TAG_BITS-1:0]      below_tag,
	input  logic signed [PRIORITY_BITS-1:0] above_prio,
	input  logic        [TAG_BITS-1:0]      above_tag,
	output logic signed [PRIORITY_BITS-1:0] prio,
	output logic        [TAG_BITS-1:0]      tag,
	output logic                            ge
);
	import spq_pkg::*;

	logic signed [PRIORITY_BITS-1:0] prio_q, prio_d;
	logic        [TAG_BITS-1:0]      tag_q, tag_d;

	// empty slot or entry not below the new one: this cell moves up
	assign ge = !occupied || (prio_q >= new_prio);

	always_comb begin
		prio_d = prio_q;
		tag_d  = tag_q;
		priority if (ctrl.enq && ge) begin
			if (below_ge) begin
				prio_d = below_prio;
				tag_d  = below_tag;
			end else begin
				prio_d = new_prio;
				tag_d  = new_tag;
			end
		end else if (ctrl.deq) begin
			prio_d = above_prio;
			tag_d  = above_tag;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		tag_q  <= tag_d;
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

@@ rtl/spq_outbuf.sv @@
// ----------------------------------------------------------------------------
// spq_outbuf: result register with skid stage
// lets a new request be taken while a finished result waits downstream
// ----------------------------------------------------------------------------
module spq_outbuf #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);
	import spq_pkg::*;

	logic             out_valid_q, skid_valid_q;
	logic [WIDTH-1:0] out_data_q, skid_data_q;
	logic             take;

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed while skid stage is occupied");

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a chain of sorted cells
// enqueue, dequeue, peek and clear with one result per request
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries of a signed priority and a tag in a
// row of cells kept sorted with the smallest priority in cell 0, so dequeue
// and peek read cell 0 directly. Enqueue places the new entry below all
// entries of equal or greater priority (the newest of equal priorities leaves
// first); every cell decides locally from its own compare and its lower
// neighbor's whether to keep, take the new entry or shift up. Dequeue shifts
// the whole row down by one cell. The result of each request is registered in the
// output register, or in the skid stage while a waiting result holds the output
// register; one request is accepted per cycle while in_stall is low. A skid stage
// behind the output register keeps requests flowing while one result waits,
// so in_stall rises only when two results are held. An enqueue into a full
// queue returns status full, a dequeue or peek on an empty queue returns
// status empty; neither changes the queue. Priority and tag of the result are
// zero unless a dequeue or peek succeeds. There is no clearing pass after
// reset: only the entry count is reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
	localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [spq_pkg::CMD_BITS-1:0]     cmd,
	input  logic signed [PRIORITY_BITS-1:0]  in_priority,
	input  logic [TAG_BITS-1:0]              in_tag,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [PRIORITY_BITS-1:0]  out_priority,
	output logic [TAG_BITS-1:0]              out_tag,
	output logic [spq_pkg::STATUS_BITS-1:0]  status,
	output logic [CNT_W-1:0]                 occupancy
);
	import spq_pkg::*;

	localparam int RES_W = PRIORITY_BITS + TAG_BITS + STATUS_BITS + CNT_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// request decode
	logic              accept;
	cmd_t              cmd_e;
	logic              is_full, is_empty;
	cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]  count_q, count_d;

	// cell chain taps
	logic signed [PRIORITY_BITS-1:0] prio_w [CAPACITY];
	logic        [TAG_BITS-1:0]      tag_w  [CAPACITY];
	logic                            ge_w   [CAPACITY];

	// result assembly
	logic signed [PRIORITY_BITS-1:0] res_prio;
	logic        [TAG_BITS-1:0]      res_tag;
	status_t                         res_status;
	logic [RES_W-1:0]                res_data, out_data;
	logic                            buf_full;

	assign accept   = in_valid && !in_stall;
	assign cmd_e    = cmd_t'(cmd);
	assign is_full  = (count_q == CAP_CNT);
	assign is_empty = (count_q == '0);

	assign ctrl.enq = accept && (cmd_e == CMD_ENQUEUE) && !is_full;
	assign ctrl.deq = accept && (cmd_e == CMD_DEQUEUE) && !is_empty;

	// entry count
	always_comb begin
		count_d = count_q;
		unique case (cmd_e)
			CMD_ENQUEUE: if (!is_full)  count_d = count_q + CNT_W'(1);
			CMD_DEQUEUE: if (!is_empty) count_d = count_q - CNT_W'(1);
			CMD_PEEK:    count_d = count_q;
			CMD_CLEAR:   count_d = '0;
			default:     count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// sorted chain, smallest priority in cell 0
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic                            occ;
		logic                            b_ge;
		logic signed [PRIORITY_BITS-1:0] b_prio, a_prio;
		logic        [TAG_BITS-1:0]      b_tag, a_tag;

		assign occ = (CNT_W'(j) < count_q);

		if (j == 0) begin : g_bottom
			assign b_ge   = 1'b0;
			assign b_prio = in_priority;
			assign b_tag  = in_tag;
		end else begin : g_inner_below
			assign b_ge   = ge_w[j-1];
			assign b_prio = prio_w[j-1];
			assign b_tag  = tag_w[j-1];
		end

		if (j == CAPACITY - 1) begin : g_top
			// top cell keeps its own entry on a shift down
			assign a_prio = prio_w[j];
			assign a_tag  = tag_w[j];
		end else begin : g_inner_above
			assign a_prio = prio_w[j+1];
			assign a_tag  = tag_w[j+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.TAG_BITS     (TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (occ),
			.new_prio  (in_priority),
			.new_tag   (in_tag),
			.below_ge  (b_ge),
			.below_prio(b_prio),
			.below_tag (b_tag),
			.above_prio(a_prio),
			.above_tag (a_tag),
			.prio      (prio_w[j]),
			.tag       (tag_w[j]),
			.ge        (ge_w[j])
		);
	end

	// result of the request, cell 0 read before the chain updates
	always_comb begin
		res_prio   = '0;
		res_tag    = '0;
		res_status = ST_OK;
		unique case (cmd_e)
			CMD_ENQUEUE: if (is_full) res_status = ST_FULL;
			CMD_DEQUEUE, CMD_PEEK: begin
				if (is_empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_prio = prio_w[0];
					res_tag  = tag_w[0];
				end
			end
			CMD_CLEAR:   res_status = ST_OK;
			default:     res_status = ST_OK;
		endcase
	end

	assign res_data = {res_prio, res_tag, res_status, count_d};

	spq_outbuf #(
		.WIDTH(RES_W)
	) u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(res_data),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign in_stall = buf_full;
	assign {out_priority, out_tag, status, occupancy} = out_data;

	// count never runs past the row of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count exceeds capacity");

	// a successful enqueue grows the queue by exactly one
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("enqueue did not add one entry");

	// the two lowest cells stay in order
	a_bottom_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> prio_w[0] <= prio_w[1])
		else $error("cell chain out of order at the bottom");

	// a successful dequeue shrinks the queue by exactly one
	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("dequeue did not remove one entry");

endmodule
